>>> sv/ksh_pkg.sv
// Shared types and constants for the Keccak sponge hash unit.
`timescale 1ns / 1ps
package ksh_pkg;
	localparam int STATE_BYTES = 200;
	localparam logic [7:0] LFSR_SEED = 8'hB8;
	localparam logic [7:0] LFSR_TAPS = 8'h71;
	localparam logic [7:0] PAD_END = 8'h80;

	localparam logic [1:0] CFG_RATE = 2'd0;
	localparam logic [1:0] CFG_DELIM = 2'd1;
	localparam logic [1:0] CFG_ROUNDS = 2'd2;
	localparam logic [1:0] CFG_OUTLEN = 2'd3;

	localparam logic [1:0] MODE_ABSORB = 2'd0;
	localparam logic [1:0] MODE_ABSORB_FIN = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABS_PERM,
		ST_DELIM,
		ST_DELIM_PERM,
		ST_PAD,
		ST_PAD_PERM,
		ST_OUT,
		ST_OUT_PERM,
		ST_CLEAR
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic       xor_en;     // xor xor_val at xor_idx
		logic [7:0] xor_idx;
		logic [7:0] xor_val;
		logic       perm_start; // start a permutation
		logic       clear;      // zero the state
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic       perm_busy;
	} dp_sts_t;

	// Rotation offsets, lane index x+5y.
	function automatic logic [5:0] rho_off(input int idx);
		logic [5:0] t [25];
		t = '{6'd0, 6'd1, 6'd62, 6'd28, 6'd27,
			6'd36, 6'd44, 6'd6, 6'd55, 6'd20,
			6'd3, 6'd10, 6'd43, 6'd25, 6'd39,
			6'd41, 6'd45, 6'd15, 6'd21, 6'd8,
			6'd18, 6'd2, 6'd61, 6'd56, 6'd14};
		return t[idx];
	endfunction

	function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] n);
		logic [127:0] d;
		d = {v, v} << n;
		return d[127:64];
	endfunction
endpackage

>>> sv/keccak_sponge_hash_unit.sv
// Keccak-f[1600] sponge hash unit: top level.
// One request on s_axis absorbs a byte (mode 0), absorbs a byte and finishes (mode 1) or
// finishes with no byte (mode 2); mode 3 is dropped. When an absorbed byte fills the
// rate, a permutation follows (one round per cycle in the datapath round unit,
// round_count capped at MAX_ROUNDS), and s_axis is held off until it ends. A finish
// runs the padding (one or two permutations) and then emits output_bytes digest bytes
// on m_axis, one per cycle at most, with another permutation each time the rate is
// read out, and tlast on the final byte. The state is cleared in the cycle after the
// last byte enters the output register, whether or not m_axis has taken it yet. A
// one-entry output register lets the sequencer run while m_axis stalls.
// Configuration writes (cfg_we/cfg_idx/cfg_data) take effect at once and must only be
// issued while the unit is idle.
`timescale 1ns / 1ps
module keccak_sponge_hash_unit #(
	parameter int MAX_OUTPUT_BYTES = 64,
	parameter int MAX_ROUNDS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [1:0]  s_axis_tuser,  // [1:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] hash_byte
	output logic        m_axis_tlast   // last_byte
);
	ksh_pkg::dp_cmd_t cmd;
	ksh_pkg::dp_sts_t sts;
	logic [4:0] rounds;
	logic [7:0] rd_idx, rd_byte;

	ksh_ctrl #(.MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES), .MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_mode(s_axis_tuser), .in_byte(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_byte(m_axis_tdata), .out_last(m_axis_tlast),
		.cmd, .sts, .rounds, .rd_idx, .rd_byte
	);

	ksh_datapath u_dp (
		.clk, .arst_n, .cmd, .rounds, .rd_idx, .rd_byte, .sts
	);

	// Never accept a request while a permutation runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.perm_busy && !cmd.perm_start |-> !s_axis_tready)
		else $error("request accepted during permutation");
	// State is never written by a byte xor while a permutation runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.xor_en && sts.perm_busy && !cmd.perm_start))
		else $error("byte xor during permutation");
	// Clear and permutation start never coincide.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear && cmd.perm_start))
		else $error("clear during permutation start");
endmodule

>>> sv/ksh_datapath.sv
// Sponge state register with byte xor port, byte read port and round unit.
`timescale 1ns / 1ps
module ksh_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  ksh_pkg::dp_cmd_t cmd,
	input  logic [4:0]       rounds,
	input  logic [7:0]       rd_idx,
	output logic [7:0]       rd_byte,
	output ksh_pkg::dp_sts_t sts
);
	logic [63:0] lane_q [25];
	logic [63:0] rnd [25];
	logic [4:0]  rnd_q;
	logic        busy_q;
	logic [7:0]  lfsr_q;
	logic [7:0]  lfsr_nx;
	logic [63:0] rc;

	// One Keccak round, with the round constant produced by seven LFSR steps.
	always_comb begin
		logic [63:0] c [5];
		logic [63:0] a [25];
		logic [63:0] b [25];
		logic [7:0]  l;
		for (int x = 0; x < 5; x++)
			c[x] = lane_q[x] ^ lane_q[x+5] ^ lane_q[x+10] ^ lane_q[x+15] ^ lane_q[x+20];
		for (int x = 0; x < 5; x++)
			for (int y = 0; y < 5; y++)
				a[x+5*y] = lane_q[x+5*y] ^ c[(x+4)%5] ^ ksh_pkg::rotl(c[(x+1)%5], 6'd1);
		for (int x = 0; x < 5; x++)
			for (int y = 0; y < 5; y++)
				b[y + 5*((2*x+3*y)%5)] = ksh_pkg::rotl(a[x+5*y], ksh_pkg::rho_off(x+5*y));
		for (int y = 0; y < 5; y++)
			for (int x = 0; x < 5; x++)
				rnd[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
		l = lfsr_q;
		rc = '0;
		for (int j = 0; j < 7; j++) begin
			rc[(1 << j) - 1] = l[7];
			l = l[7] ? ((l << 1) ^ ksh_pkg::LFSR_TAPS) : (l << 1);
		end
		lfsr_nx = l;
		rnd[0] = rnd[0] ^ rc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= '0;
			lfsr_q <= ksh_pkg::LFSR_SEED;
		end else if (cmd.perm_start) begin
			busy_q <= (rounds != 5'd0);
			rnd_q <= rounds;
			lfsr_q <= ksh_pkg::LFSR_SEED;
		end else if (busy_q) begin
			lfsr_q <= lfsr_nx;
			rnd_q <= rnd_q - 5'd1;
			busy_q <= (rnd_q != 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 25; i++) lane_q[i] <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < 25; i++) lane_q[i] <= '0;
		end else if (busy_q) begin
			for (int i = 0; i < 25; i++) lane_q[i] <= rnd[i];
		end else if (cmd.xor_en) begin
			lane_q[cmd.xor_idx[7:3]][{cmd.xor_idx[2:0], 3'b000} +: 8] <=
				lane_q[cmd.xor_idx[7:3]][{cmd.xor_idx[2:0], 3'b000} +: 8] ^ cmd.xor_val;
		end
	end

	assign rd_byte = lane_q[rd_idx[7:3]][{rd_idx[2:0], 3'b000} +: 8];
	assign sts.perm_busy = busy_q | cmd.perm_start;
endmodule

>>> sv/ksh_ctrl.sv
// Sequencer for absorb, padding, squeeze and clear.
`timescale 1ns / 1ps
module ksh_ctrl #(
	parameter int MAX_OUTPUT_BYTES = 64,
	parameter int MAX_ROUNDS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [7:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_mode,
	input  logic [7:0]       in_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output ksh_pkg::dp_cmd_t cmd,
	input  ksh_pkg::dp_sts_t sts,
	output logic [4:0]       rounds,
	output logic [7:0]       rd_idx,
	input  logic [7:0]       rd_byte
);
	ksh_pkg::state_t state_q, state_d;
	logic [7:0] rate_q, delim_q, pos_q, pos_d, opos_q, opos_d;
	logic [4:0] rcount_q;
	logic [6:0] olen_q, ocnt_q, ocnt_d;
	logic [7:0] rate, pos_eff;
	logic [6:0] count;
	logic       obuf_v_q, obuf_v_d, obuf_l_q, obuf_l_d;
	logic [7:0] obuf_q, obuf_d;

	assign rate = (rate_q == 8'd0) ? 8'd1 :
		(rate_q > 8'(ksh_pkg::STATE_BYTES)) ? 8'(ksh_pkg::STATE_BYTES) : rate_q;
	assign pos_eff = (pos_q >= rate) ? 8'd0 : pos_q;
	assign rounds = (rcount_q > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : rcount_q;
	assign count = (olen_q == 7'd0) ? 7'd1 :
		(olen_q > 7'(MAX_OUTPUT_BYTES)) ? 7'(MAX_OUTPUT_BYTES) : olen_q;
	assign rd_idx = opos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 8'd72;
			delim_q <= 8'd1;
			rcount_q <= 5'd24;
			olen_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ksh_pkg::CFG_RATE:   rate_q <= cfg_data;
				ksh_pkg::CFG_DELIM:  delim_q <= cfg_data;
				ksh_pkg::CFG_ROUNDS: rcount_q <= cfg_data[4:0];
				ksh_pkg::CFG_OUTLEN: olen_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksh_pkg::ST_IDLE;
			pos_q <= '0;
			opos_q <= '0;
			ocnt_q <= '0;
			obuf_v_q <= 1'b0;
			obuf_l_q <= 1'b0;
			obuf_q <= '0;
		end else begin
			state_q <= state_d;
			pos_q <= pos_d;
			opos_q <= opos_d;
			ocnt_q <= ocnt_d;
			obuf_v_q <= obuf_v_d;
			obuf_l_q <= obuf_l_d;
			obuf_q <= obuf_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pos_d = pos_q;
		opos_d = opos_q;
		ocnt_d = ocnt_q;
		obuf_v_d = obuf_v_q & ~out_ready;
		obuf_l_d = obuf_l_q;
		obuf_d = obuf_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ksh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_mode != ksh_pkg::MODE_UNUSED) begin
					pos_d = pos_eff;
					if (in_mode != ksh_pkg::MODE_FINISH) begin
						cmd.xor_en = 1'b1;
						cmd.xor_idx = pos_eff;
						cmd.xor_val = in_byte;
						pos_d = pos_eff + 8'd1;
						if (pos_eff + 8'd1 == rate) begin
							cmd.perm_start = 1'b1;
							pos_d = '0;
						end
					end
					if (in_mode == ksh_pkg::MODE_ABSORB)
						state_d = (pos_eff + 8'd1 == rate) ? ksh_pkg::ST_ABS_PERM
							: ksh_pkg::ST_IDLE;
					else
						state_d = ksh_pkg::ST_DELIM;
				end
			end
			ksh_pkg::ST_ABS_PERM:
				if (!sts.perm_busy) state_d = ksh_pkg::ST_IDLE;
			ksh_pkg::ST_DELIM: begin
				if (!sts.perm_busy) begin
					cmd.xor_en = 1'b1;
					cmd.xor_idx = pos_q;
					cmd.xor_val = delim_q;
					if (pos_q + 8'd1 == rate && delim_q[7])
						state_d = ksh_pkg::ST_DELIM_PERM;
					else
						state_d = ksh_pkg::ST_PAD;
				end
			end
			ksh_pkg::ST_DELIM_PERM: begin
				cmd.perm_start = 1'b1;
				state_d = ksh_pkg::ST_PAD;
			end
			ksh_pkg::ST_PAD: begin
				if (!sts.perm_busy) begin
					cmd.xor_en = 1'b1;
					cmd.xor_idx = rate - 8'd1;
					cmd.xor_val = ksh_pkg::PAD_END;
					state_d = ksh_pkg::ST_PAD_PERM;
				end
			end
			ksh_pkg::ST_PAD_PERM: begin
				cmd.perm_start = 1'b1;
				opos_d = '0;
				ocnt_d = '0;
				state_d = ksh_pkg::ST_OUT;
			end
			ksh_pkg::ST_OUT: begin
				if (!sts.perm_busy && (!obuf_v_q || out_ready)) begin
					obuf_v_d = 1'b1;
					obuf_d = rd_byte;
					obuf_l_d = (ocnt_q + 7'd1 == count);
					ocnt_d = ocnt_q + 7'd1;
					opos_d = opos_q + 8'd1;
					if (ocnt_q + 7'd1 == count)
						state_d = ksh_pkg::ST_CLEAR;
					else if (opos_q + 8'd1 == rate)
						state_d = ksh_pkg::ST_OUT_PERM;
				end
			end
			ksh_pkg::ST_OUT_PERM: begin
				cmd.perm_start = 1'b1;
				opos_d = '0;
				state_d = ksh_pkg::ST_OUT;
			end
			ksh_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				pos_d = '0;
				state_d = ksh_pkg::ST_IDLE;
			end
			default: state_d = ksh_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = obuf_v_q;
	assign out_byte = obuf_q;
	assign out_last = obuf_l_q;
endmodule

>>> tb/sv/keccak_sponge_hash_unit_tb.sv
// Self-checking testbench for the Keccak sponge hash unit.
`timescale 1ns / 1ps
module keccak_sponge_hash_unit_tb;
	localparam int STALL_LIMIT = 20000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_data;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;  // [7:0] data_byte
	logic [1:0] s_axis_tuser;  // [1:0] mode
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;  // [7:0] hash_byte
	logic       m_axis_tlast;  // last_byte

	keccak_sponge_hash_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// 12 ns period
	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// Predictor state: lanes, position, registers.
	logic [63:0] lanes [25];
	logic [7:0]  abs_pos;
	logic [7:0]  rate_reg, delim_reg, out_reg;
	logic [4:0]  rounds_reg;

	typedef struct packed {
		logic [7:0] hash_byte;
		logic       last_byte;
	} digest_t;
	digest_t digest_q [$];

	int fail_cnt;
	int send_idle_pct, recv_idle_pct;
	bit recv_hold;
	int quiet_cycles;

	function automatic logic [63:0] rot64(input logic [63:0] v, input int n);
		n = n % 64;
		if (n == 0)
			return v;
		return (v << n) | (v >> (64 - n));
	endfunction

	task automatic keccak_permute();
		int nr;
		logic [7:0] lfsr;
		logic [63:0] c [5];
		logic [63:0] row [5];
		logic [63:0] d, carry, held, rc;
		int x, y, ny;
		nr = (rounds_reg > 24) ? 24 : rounds_reg;
		lfsr = ksh_pkg::LFSR_SEED;
		for (int r = 0; r < nr; r++) begin
			for (x = 0; x < 5; x++)
				c[x] = lanes[x] ^ lanes[x+5] ^ lanes[x+10] ^ lanes[x+15] ^ lanes[x+20];
			for (x = 0; x < 5; x++) begin
				d = c[(x+4)%5] ^ rot64(c[(x+1)%5], 1);
				for (y = 0; y < 5; y++)
					lanes[x+5*y] ^= d;
			end
			// rho and pi walked along the lane cycle
			x = 1; y = 0;
			carry = lanes[1];
			for (int t = 0; t < 24; t++) begin
				ny = (2*x + 3*y) % 5;
				x = y;
				y = ny;
				held = lanes[x+5*y];
				lanes[x+5*y] = rot64(carry, (((t+1)*(t+2)) / 2) % 64);
				carry = held;
			end
			for (y = 0; y < 5; y++) begin
				for (x = 0; x < 5; x++)
					row[x] = lanes[x+5*y];
				for (x = 0; x < 5; x++)
					lanes[x+5*y] = row[x] ^ (~row[(x+1)%5] & row[(x+2)%5]);
			end
			rc = '0;
			for (int j = 0; j <= 6; j++) begin
				if (lfsr[7]) begin
					rc[(1 << j) - 1] = 1'b1;
					lfsr = (lfsr << 1) ^ ksh_pkg::LFSR_TAPS;
				end else begin
					lfsr = lfsr << 1;
				end
			end
			lanes[0] ^= rc;
		end
	endtask

	function automatic void xor_state(input int idx, input logic [7:0] v);
		if (idx < ksh_pkg::STATE_BYTES)
			lanes[idx/8][8*(idx%8) +: 8] ^= v;
	endfunction

	function automatic void clear_sponge();
		for (int i = 0; i < 25; i++)
			lanes[i] = '0;
		abs_pos = '0;
	endfunction

	// Works out the digest bytes caused by one accepted request.
	task automatic predict_request(input logic [1:0] mode, input logic [7:0] data);
		int rate, pos, cnt, rd;
		if (mode == ksh_pkg::MODE_UNUSED)
			return;
		rate = (rate_reg == 0) ? 1 : (rate_reg > 200 ? 200 : rate_reg);
		pos = (abs_pos >= rate) ? 0 : abs_pos;
		if (mode != ksh_pkg::MODE_FINISH) begin
			xor_state(pos, data);
			pos++;
			if (pos == rate) begin
				keccak_permute();
				pos = 0;
			end
		end
		if (mode == ksh_pkg::MODE_ABSORB) begin
			abs_pos = 8'(pos);
			return;
		end
		xor_state(pos, delim_reg);
		pos++;
		// delimiter on the last rate byte with bit 7 set: extra permutation
		if (pos == rate && delim_reg[7])
			keccak_permute();
		xor_state(rate - 1, ksh_pkg::PAD_END);
		keccak_permute();
		cnt = (out_reg == 0) ? 1 : (out_reg > 64 ? 64 : out_reg);
		rd = 0;
		for (int i = 0; i < cnt; i++) begin
			digest_q.push_back({lanes[rd/8][8*(rd%8) +: 8], (i + 1 == cnt)});
			rd++;
			if (rd == rate) begin
				keccak_permute();
				rd = 0;
			end
		end
		clear_sponge();
	endtask

	// Drives one request and waits for its acceptance; valid stays up afterwards.
	task automatic send_request(input logic [1:0] mode, input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_request(mode, data);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ksh_pkg::CFG_RATE: rate_reg = val;
			ksh_pkg::CFG_DELIM: delim_reg = val;
			ksh_pkg::CFG_ROUNDS: rounds_reg = val[4:0];
			default: out_reg = val[6:0];
		endcase
		@(posedge clk);
	endtask

	// Drain outstanding digest bytes, then let any permutation finish.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] rate, input logic [7:0] delim,
		input logic [4:0] nr, input logic [6:0] olen);
		wait_idle();
		write_reg(ksh_pkg::CFG_RATE, rate);
		write_reg(ksh_pkg::CFG_DELIM, delim);
		write_reg(ksh_pkg::CFG_ROUNDS, {3'b0, nr});
		write_reg(ksh_pkg::CFG_OUTLEN, {1'b0, olen});
	endtask

	// Receiver: random stalls plus an optional long hold-off.
	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// Digest byte checker.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest byte %h", m_axis_tdata);
				fail_cnt++;
			end else begin
				digest_t exp_b;
				exp_b = digest_q.pop_front();
				if (m_axis_tdata !== exp_b.hash_byte) begin
					$error("hash_byte expected %h actual %h", exp_b.hash_byte, m_axis_tdata);
					fail_cnt++;
				end
				if (m_axis_tlast !== exp_b.last_byte) begin
					$error("last_byte expected %b actual %b", exp_b.last_byte, m_axis_tlast);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no request or digest byte moving.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		// default config: Keccak-512 of empty message
		send_request(ksh_pkg::MODE_FINISH, 8'h00);
		send_request(ksh_pkg::MODE_ABSORB, 8'hFF);
		send_request(ksh_pkg::MODE_ABSORB, 8'h00);
		send_request(ksh_pkg::MODE_UNUSED, 8'hA5);    // dropped
		send_request(ksh_pkg::MODE_ABSORB_FIN, 8'h5A);
		// rate 1, delimiter with bit 7, zero rounds, single byte output
		set_config(8'd0, 8'h86, 5'd0, 7'd0);
		send_request(ksh_pkg::MODE_ABSORB_FIN, 8'h55);
		set_config(8'd2, 8'h86, 5'd3, 7'd5);
		send_request(ksh_pkg::MODE_ABSORB, 8'hAA);
		send_request(ksh_pkg::MODE_FINISH, 8'h00);
		// delimiter without bit 7 on the last byte
		set_config(8'd2, 8'h06, 5'd31, 7'd127);
		send_request(ksh_pkg::MODE_ABSORB_FIN, 8'h01);
		set_config(8'd255, 8'h1F, 5'd24, 7'd64);
		send_request(ksh_pkg::MODE_ABSORB, 8'h80);
		send_request(ksh_pkg::MODE_ABSORB_FIN, 8'h7F);
		// rate lowered mid-message: position wraps to zero
		set_config(8'd200, 8'h06, 5'd24, 7'd3);
		repeat (5) send_request(ksh_pkg::MODE_ABSORB, 8'h33);
		wait_idle();
		write_reg(ksh_pkg::CFG_RATE, 8'd3);
		send_request(ksh_pkg::MODE_ABSORB_FIN, 8'hC3);
	endtask

	task automatic test_random(input int n_items);
		int sent;
		logic [1:0] mode;
		sent = 0;
		while (sent < n_items) begin
			set_config(8'($urandom_range(1, 40)), 8'($urandom_range(255)),
				5'($urandom_range(1, 24)), 7'($urandom_range(1, 64)));
			// mostly short messages ending in a finish
			for (int k = $urandom_range(0, 30); k > 0; k--) begin
				mode = ($urandom_range(19) == 0) ? ksh_pkg::MODE_UNUSED : ksh_pkg::MODE_ABSORB;
				send_request(mode, 8'($urandom_range(255)));
				sent++;
			end
			send_request($urandom_range(1) ? ksh_pkg::MODE_ABSORB_FIN : ksh_pkg::MODE_FINISH,
				8'($urandom_range(255)));
			sent++;
		end
	endtask

	task automatic test_backpressure();
		set_config(8'd4, 8'h06, 5'd24, 7'd64);
		fork
			begin
				recv_hold = 1'b1;
				repeat (600) @(posedge clk);
				recv_hold = 1'b0;
			end
			for (int k = 0; k < 6; k++)
				send_request(ksh_pkg::MODE_ABSORB_FIN, 8'($urandom_range(255)));
		join
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
		fail_cnt = 0; recv_hold = 1'b0;
		rate_reg = 8'd72; delim_reg = 8'd1; rounds_reg = 5'd24; out_reg = 7'd64;
		clear_sponge();
		send_idle_pct = 33; recv_idle_pct = 77;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(130);
		send_idle_pct = 77; recv_idle_pct = 33;
		test_random(130);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(130);
		test_backpressure();

		wait_idle();
		if (fail_cnt == 0 && digest_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> keccak_sponge_hash_unit.f
sv/ksh_pkg.sv
sv/ksh_datapath.sv
sv/ksh_ctrl.sv
sv/keccak_sponge_hash_unit.sv
tb/sv/keccak_sponge_hash_unit_tb.sv
